### hw/rtl/wsdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int MAXLEN_W    = 32;
    localparam int CMP_W       = (LENGTH_BITS > MAXLEN_W) ? LENGTH_BITS : MAXLEN_W;

    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(10 * 1024 * 1024);

    localparam logic [7:0] HDR_RSV_MASK = 8'h70;
    localparam logic [6:0] LEN7_EXT16   = 7'd126;
    localparam logic [6:0] LEN7_EXT64   = 7'd127;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_RSV      = 2'd0;
    localparam logic [1:0] ERR_CTRL_EXT = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_HDR,
        CMD_KEY,
        CMD_DATA,
        CMD_EMPTY,
        CMD_ERROR
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data;
        logic        masked;
        logic        last;
        logic [1:0]  err;
    } t_op;

endpackage

### hw/rtl/wsdf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_front
// Header parser: walks the frame header, checks lengths and classifies
// header, key and payload bytes into operations for the back end.
// ----------------------------------------------------------------------------
module wsdf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wsdf_pkg::MAXLEN_W-1:0]  i_cfg_wdata,
    input  logic                           i_valid,
    input  logic [7:0]                     i_byte,
    output logic                           o_ready,
    input  logic                           i_full,
    output logic                           o_push,
    output wsdf_pkg::t_op                  o_op
);
    import wsdf_pkg::*;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_LEN7   = 7'b0000010,
        PH_LEN16  = 7'b0000100,
        PH_LEN64  = 7'b0001000,
        PH_KEY    = 7'b0010000,
        PH_DATA   = 7'b0100000,
        PH_ERR    = 7'b1000000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic                   r_ctrl, n_ctrl;
    logic                   r_masked, n_masked;
    logic [LENGTH_BITS-1:0] r_shift, n_shift;
    logic                   r_ovf, n_ovf;
    logic [2:0]             r_cnt, n_cnt;
    logic [LENGTH_BITS-1:0] r_remain, n_remain;
    logic [MAXLEN_W-1:0]    r_max_len;

    logic                   accept;
    logic                   len_done;
    logic                   len_ovf;
    logic [LENGTH_BITS-1:0] len_cand;
    logic                   masked_now;
    logic                   push;
    t_op                    op;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = push;
    assign o_op    = op;

    always_comb begin
        n_phase    = r_phase;
        n_ctrl     = r_ctrl;
        n_masked   = r_masked;
        n_shift    = r_shift;
        n_ovf      = r_ovf;
        n_cnt      = r_cnt;
        n_remain   = r_remain;
        push       = 1'b0;
        op.cmd     = CMD_HDR;
        op.data    = i_byte;
        op.masked  = r_masked;
        op.last    = 1'b0;
        op.err     = ERR_RSV;
        len_done   = 1'b0;
        len_ovf    = 1'b0;
        len_cand   = '0;
        masked_now = (r_phase == PH_LEN7) ? i_byte[7] : r_masked;
        if (accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    push = 1'b1;
                    if ((i_byte & HDR_RSV_MASK) != 8'h00) begin
                        op.cmd  = CMD_ERROR;
                        op.err  = ERR_RSV;
                        n_phase = PH_ERR;
                    end else begin
                        op.cmd  = CMD_HDR;
                        n_ctrl  = i_byte[3];
                        n_phase = PH_LEN7;
                    end
                end
                PH_LEN7: begin
                    n_masked = i_byte[7];
                    n_shift  = '0;
                    n_ovf    = 1'b0;
                    n_cnt    = '0;
                    if (r_ctrl && (i_byte[6:0] >= LEN7_EXT16)) begin
                        push    = 1'b1;
                        op.cmd  = CMD_ERROR;
                        op.err  = ERR_CTRL_EXT;
                        n_phase = PH_ERR;
                    end else if (i_byte[6:0] == LEN7_EXT16) begin
                        n_phase = PH_LEN16;
                    end else if (i_byte[6:0] == LEN7_EXT64) begin
                        n_phase = PH_LEN64;
                    end else begin
                        len_done = 1'b1;
                        len_cand = LENGTH_BITS'(i_byte[6:0]);
                    end
                end
                PH_LEN16, PH_LEN64: begin
                    len_cand = {r_shift[LENGTH_BITS-9:0], i_byte};
                    len_ovf  = r_ovf || (r_shift[LENGTH_BITS-1 -: 8] != 8'h00);
                    n_shift  = len_cand;
                    n_ovf    = len_ovf;
                    n_cnt    = r_cnt + 3'd1;
                    len_done = ((r_phase == PH_LEN16) && (r_cnt == 3'd1)) ||
                               ((r_phase == PH_LEN64) && (r_cnt == 3'd7));
                end
                PH_KEY: begin
                    push   = 1'b1;
                    op.cmd = CMD_KEY;
                    n_cnt  = r_cnt + 3'd1;
                    if (r_cnt == 3'd3) begin
                        n_cnt = '0;
                        if (r_remain == '0) begin
                            op.last = 1'b1;
                            n_phase = PH_HEADER;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    push     = 1'b1;
                    op.cmd   = CMD_DATA;
                    n_remain = r_remain - LENGTH_BITS'(1);
                    op.last  = (r_remain == LENGTH_BITS'(1));
                    if (r_remain == LENGTH_BITS'(1)) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_ERR: begin
                    push = 1'b0;
                end
                default: begin
                    n_phase = PH_ERR;
                end
            endcase
            if (len_done) begin
                if (len_ovf || (CMP_W'(len_cand) > CMP_W'(r_max_len))) begin
                    push    = 1'b1;
                    op.cmd  = CMD_ERROR;
                    op.err  = ERR_TOO_LONG;
                    n_phase = PH_ERR;
                end else begin
                    n_remain = len_cand;
                    n_cnt    = '0;
                    if (masked_now) begin
                        n_phase = PH_KEY;
                    end else if (len_cand == '0) begin
                        push    = 1'b1;
                        op.cmd  = CMD_EMPTY;
                        op.last = 1'b1;
                        n_phase = PH_HEADER;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_ctrl    <= 1'b0;
            r_masked  <= 1'b0;
            r_shift   <= '0;
            r_ovf     <= 1'b0;
            r_cnt     <= '0;
            r_remain  <= '0;
            r_max_len <= MAXLEN_RESET;
        end else begin
            r_phase  <= n_phase;
            r_ctrl   <= n_ctrl;
            r_masked <= n_masked;
            r_shift  <= n_shift;
            r_ovf    <= n_ovf;
            r_cnt    <= n_cnt;
            r_remain <= n_remain;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && i_full))
        else $error("push into a full queue");

    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERR) |=> (r_phase == PH_ERR))
        else $error("left the error phase without reset");

    a_error_enters_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && (op.cmd == CMD_ERROR)) |=> (r_phase == PH_ERR))
        else $error("error beat without entering the error phase");
`endif

endmodule

### hw/rtl/wsdf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_queue
// Short operation queue between the header parser and the back end.
// ----------------------------------------------------------------------------
module wsdf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsdf_pkg::t_op  i_op,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_avail,
    output wsdf_pkg::t_op  o_op
);
    import wsdf_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

### hw/rtl/wsdf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_back
// Back end: tracks frame flags and masking key, unmasks payload and holds
// the result register.
// ----------------------------------------------------------------------------
module wsdf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  wsdf_pkg::t_op  i_op,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_payload_byte,
    output logic [3:0]     o_frame_opcode,
    output logic           o_final_fragment,
    output logic           o_last_of_frame,
    output logic [1:0]     o_error_code
);
    import wsdf_pkg::*;

    logic [31:0] r_key;
    logic [1:0]  r_key_pos;
    logic [3:0]  r_opcode;
    logic        r_fin;
    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic [3:0]  r_out_opcode;
    logic        r_out_fin;
    logic        r_last;
    logic [1:0]  r_err;

    logic        makes_out;
    logic        pop;
    logic [1:0]  key_sel;
    logic [7:0]  key_byte;
    logic [7:0]  plain;

    always_comb begin
        unique case (i_op.cmd)
            CMD_DATA, CMD_EMPTY, CMD_ERROR: makes_out = 1'b1;
            CMD_KEY:                        makes_out = i_op.last;
            default:                        makes_out = 1'b0;
        endcase
    end

    assign pop      = i_avail && (!makes_out || !r_valid || i_ready);
    assign o_pop    = pop;
    assign key_sel  = 2'd3 - r_key_pos;
    assign key_byte = r_key[{key_sel, 3'b000} +: 8];
    assign plain    = i_op.masked ? (i_op.data ^ key_byte) : i_op.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_key_pos <= '0;
            r_opcode  <= '0;
            r_fin     <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (pop && makes_out) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (pop) begin
                unique case (i_op.cmd)
                    CMD_HDR: begin
                        r_fin    <= i_op.data[7];
                        r_opcode <= i_op.data[3:0];
                    end
                    CMD_KEY: begin
                        r_key     <= {r_key[23:0], i_op.data};
                        r_key_pos <= '0;
                    end
                    CMD_DATA: begin
                        r_key_pos <= r_key_pos + 2'd1;
                    end
                    default: begin
                        r_key_pos <= r_key_pos;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && makes_out) begin
            r_out_opcode <= r_opcode;
            r_out_fin    <= r_fin;
            r_byte       <= 8'h00;
            r_err        <= ERR_RSV;
            r_last       <= i_op.last;
            unique case (i_op.cmd)
                CMD_DATA: begin
                    r_kind <= KIND_DATA;
                    r_byte <= plain;
                end
                CMD_ERROR: begin
                    r_kind       <= KIND_ERROR;
                    r_err        <= i_op.err;
                    r_last       <= 1'b0;
                    r_out_opcode <= 4'h0;
                    r_out_fin    <= 1'b0;
                end
                default: begin
                    r_kind <= KIND_EMPTY;
                    r_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_payload_byte   = r_byte;
    assign o_frame_opcode   = r_out_opcode;
    assign o_final_fragment = r_out_fin;
    assign o_last_of_frame  = r_last;
    assign o_error_code     = r_err;

endmodule

### hw/rtl/websocket_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Receive-side websocket frame parser, one stream byte per beat.
// ----------------------------------------------------------------------------
// rx channel: i_rx_valid / o_rx_ready carry one stream byte per beat.
// res channel: o_res_valid / i_res_ready carry one result per beat: a
//   payload byte (unmasked, last flagged), an empty-frame marker or an error.
// cfg: i_cfg_we writes the payload length limit, reset value 10 MiB.
// path: parser operation -> two-deep queue -> registered result.
// throughput: one byte per cycle while i_res_ready is high, set by the parser
//   state register and the single-entry pop of the two-deep operation queue.
// header, length and key bytes give at most an empty marker or error result;
//   after an error every further byte is accepted and dropped until reset.
// reset: synchronous, active low; parser returns to header, queue and
//   result register empty, limit back to its default.
// stall: while i_res_ready is low the result holds, the queue fills and
//   o_rx_ready drops once it is full; nothing is lost.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wsdf_pkg::MAXLEN_W-1:0]  i_cfg_wdata,
    input  logic                           i_rx_valid,
    output logic                           o_rx_ready,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic [1:0]                     o_kind,
    output logic [7:0]                     o_payload_byte,
    output logic [3:0]                     o_frame_opcode,
    output logic                           o_final_fragment,
    output logic                           o_last_of_frame,
    output logic [1:0]                     o_error_code
);
    import wsdf_pkg::*;

    logic full;
    logic push;
    t_op  push_op;
    logic pop;
    logic avail;
    t_op  head_op;

    wsdf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_rx_valid),
        .i_byte      (i_rx_byte),
        .o_ready     (o_rx_ready),
        .i_full      (full),
        .o_push      (push),
        .o_op        (push_op)
    );

    wsdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_op    (head_op)
    );

    wsdf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_avail          (avail),
        .i_op             (head_op),
        .o_pop            (pop),
        .o_valid          (o_res_valid),
        .i_ready          (i_res_ready),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_frame_opcode   (o_frame_opcode),
        .o_final_fragment (o_final_fragment),
        .o_last_of_frame  (o_last_of_frame),
        .o_error_code     (o_error_code)
    );

endmodule
